>>> rtl/core/stcrt_pkg.sv
// ----------------------------------------------------------------------------
// stcrt_pkg
// Types, codes and sizes shared by the stale channel refresh table.
// ----------------------------------------------------------------------------
`default_nettype none

package stcrt_pkg;

   // Table geometry.
   localparam int TABLE_ENTRIES = 16;
   localparam int VALUE_BITS    = 64;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

   // Field widths.
   localparam int CMD_BITS      = 3;
   localparam int CHAN_BITS     = 16;
   localparam int TIME_BITS     = 64;
   localparam int WORD_BITS     = 64;
   localparam int KIND_BITS     = 2;
   localparam int COUNT_BITS    = 5;

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int INTERVAL_BITS = 63;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(1000000000);
   localparam logic REG_REPEAT_INTERVAL = 1'b0;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_WRITE  = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_POLL   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_FORGET = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 3'd4;

   // Result kinds.
   localparam logic [KIND_BITS-1:0] KIND_FORWARD = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REEMIT  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DONE    = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_STATUS  = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]         command;
      logic [CHAN_BITS-1:0]        channel;
      logic signed [TIME_BITS-1:0] time_ns;
      logic [WORD_BITS-1:0]        sample_value;
      logic                        end_of_batch;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]        kind;
      logic [CHAN_BITS-1:0]        out_channel;
      logic signed [TIME_BITS-1:0] out_time_ns;
      logic [WORD_BITS-1:0]        out_value;
      logic [COUNT_BITS-1:0]       reemit_count;
      logic                        is_present;
      logic                        table_full;
      logic                        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POLL_SCAN,
      ST_POLL_AGE,
      ST_POLL_CHECK,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/stale_channel_refresh_table.sv
// ----------------------------------------------------------------------------
// stale_channel_refresh_table
// Tracks the last sample of up to TABLE_ENTRIES channels and re-emits stale ones.
// ----------------------------------------------------------------------------
// Commands enter on the req_ channel (valid/ready) and results leave on the
// rsp_ channel (valid/ready); the final result of each item carries last.
// The repeat interval is written through the APB-style port at address 0.
//
// One table sequencer walks the entries one per cycle, so timing is set by
// that sweep. A write that is not the end of a batch, clear and unused codes
// go straight to the result. A write that ends a batch, forget and query
// sweep all entries once. A poll with n tracked channels makes n + 1 passes
// over all entries, with an age check after each pass that finds a channel,
// and then gives the done result. req_ready is high only while the sequencer
// is idle.
//
// The result sits in an output register; when the receiver stalls, the
// sequencer halts at its next result until the register is freed.
// Reset clears every valid bit, the sequencer and the output valid flag, and
// loads the default repeat interval; entry payloads are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stale_channel_refresh_table (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  stcrt_pkg::req_type              req_payload,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output stcrt_pkg::rsp_type                    rsp_payload,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [stcrt_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire  [stcrt_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [stcrt_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                  pready
);

   localparam int N  = stcrt_pkg::TABLE_ENTRIES;
   localparam int IB = stcrt_pkg::IDX_BITS;
   localparam int CB = stcrt_pkg::CNT_BITS;
   localparam int VB = stcrt_pkg::VALUE_BITS;
   localparam int TB = stcrt_pkg::TIME_BITS;

   // Table storage.
   logic [N-1:0]                        valid_ff, valid_in;
   logic [stcrt_pkg::CHAN_BITS-1:0]     chan_mem [N];
   logic [TB-1:0]                       act_mem  [N];
   logic [VB-1:0]                       val_mem  [N];
   logic [stcrt_pkg::CHAN_BITS-1:0]     chan_rd_ff;
   logic [TB-1:0]                       act_rd_ff;
   logic [VB-1:0]                       val_rd_ff;

   // Sequencer and latched item.
   stcrt_pkg::state_type                state_ff, state_in;
   logic [stcrt_pkg::CMD_BITS-1:0]      cmd_ff, cmd_in;
   logic [stcrt_pkg::CHAN_BITS-1:0]     chan_ff, chan_in;
   logic [TB-1:0]                       time_ff, time_in;
   logic [VB-1:0]                       value_ff, value_in;
   logic [CB-1:0]                       idx_ff, idx_in;
   logic                                hit_ff, hit_in;
   logic [IB-1:0]                       hit_idx_ff, hit_idx_in;
   logic                                free_ff, free_in;
   logic [IB-1:0]                       free_idx_ff, free_idx_in;
   logic                                best_ff, best_in;
   logic [IB-1:0]                       best_idx_ff, best_idx_in;
   logic [stcrt_pkg::CHAN_BITS-1:0]     best_chan_ff, best_chan_in;
   logic                                prev_valid_ff, prev_valid_in;
   logic [stcrt_pkg::CHAN_BITS-1:0]     prev_ff, prev_in;
   logic [stcrt_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                                full_ff, full_in;
   logic                                present_ff, present_in;
   logic [TB:0]                         age_ff, age_in;

   // Output register and configuration.
   logic                                rsp_valid_ff, rsp_valid_in;
   stcrt_pkg::rsp_type                  rsp_ff, rsp_in;
   logic [stcrt_pkg::INTERVAL_BITS-1:0] interval_ff, interval_in;

   // Combinational helpers.
   logic                                accept;
   logic                                slot_free;
   logic                                scan_done;
   logic [IB-1:0]                       scan_idx;
   logic                                stale;
   logic                                emit;
   stcrt_pkg::rsp_type                  emit_data;
   logic                                tbl_we;
   logic [IB-1:0]                       tbl_waddr;
   logic                                act_we;
   logic                                csr_write;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign scan_done = (idx_ff == CB'(N));
   assign scan_idx  = idx_ff[IB-1:0];

   // An entry is stale when its age is non-negative and at least the interval.
   assign stale = !age_ff[TB] && (age_ff[TB-1:0] >= {1'b0, interval_ff});

   assign req_ready   = (state_ff == stcrt_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite
                      && (paddr[3] == stcrt_pkg::REG_REPEAT_INTERVAL);
   assign interval_in = csr_write ? pwdata[stcrt_pkg::INTERVAL_BITS-1:0] : interval_ff;

   always_comb begin
      if (paddr[3] == stcrt_pkg::REG_REPEAT_INTERVAL) begin
         prdata = {1'b0, interval_ff};
      end else begin
         prdata = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stcrt_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.command) inside
                  stcrt_pkg::CMD_WRITE: begin
                     state_in = req_payload.end_of_batch ? stcrt_pkg::ST_SCAN
                                                         : stcrt_pkg::ST_RESULT;
                  end
                  stcrt_pkg::CMD_POLL: begin
                     state_in = stcrt_pkg::ST_POLL_SCAN;
                  end
                  stcrt_pkg::CMD_FORGET, stcrt_pkg::CMD_QUERY: begin
                     state_in = stcrt_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = stcrt_pkg::ST_RESULT;
                  end
               endcase
            end
         end
         stcrt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = stcrt_pkg::ST_RESULT;
            end
         end
         stcrt_pkg::ST_POLL_SCAN: begin
            if (scan_done) begin
               state_in = best_ff ? stcrt_pkg::ST_POLL_AGE : stcrt_pkg::ST_RESULT;
            end
         end
         stcrt_pkg::ST_POLL_AGE: begin
            state_in = stcrt_pkg::ST_POLL_CHECK;
         end
         stcrt_pkg::ST_POLL_CHECK: begin
            if (!stale || slot_free) begin
               state_in = stcrt_pkg::ST_POLL_SCAN;
            end
         end
         stcrt_pkg::ST_RESULT: begin
            if (slot_free) begin
               state_in = stcrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stcrt_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and result generation.
   always_comb begin
      valid_in      = valid_ff;
      cmd_in        = cmd_ff;
      chan_in       = chan_ff;
      time_in       = time_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_chan_in  = best_chan_ff;
      prev_valid_in = prev_valid_ff;
      prev_in       = prev_ff;
      count_in      = count_ff;
      full_in       = full_ff;
      present_in    = present_ff;
      age_in        = age_ff;
      emit          = 1'b0;
      emit_data     = '0;
      tbl_we        = 1'b0;
      tbl_waddr     = hit_ff ? hit_idx_ff : free_idx_ff;
      act_we        = 1'b0;

      unique case (state_ff)
         stcrt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_payload.command;
               chan_in       = req_payload.channel;
               time_in       = req_payload.time_ns;
               value_in      = req_payload.sample_value[VB-1:0];
               idx_in        = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               best_in       = 1'b0;
               prev_valid_in = 1'b0;
               count_in      = '0;
               full_in       = 1'b0;
               present_in    = 1'b0;
               if (req_payload.command == stcrt_pkg::CMD_CLEAR) begin
                  valid_in = '0;
               end
            end
         end
         stcrt_pkg::ST_SCAN: begin
            if (!scan_done) begin
               idx_in = idx_ff + CB'(1);
               if (valid_ff[scan_idx] && (chan_rd_ff == chan_ff)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = scan_idx;
               end
               if (!valid_ff[scan_idx] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = scan_idx;
               end
            end else begin
               unique case (cmd_ff) inside
                  stcrt_pkg::CMD_WRITE: begin
                     if (hit_ff || free_ff) begin
                        tbl_we              = 1'b1;
                        valid_in[tbl_waddr] = 1'b1;
                     end else begin
                        full_in = 1'b1;
                     end
                  end
                  stcrt_pkg::CMD_FORGET: begin
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                     present_in = hit_ff;
                  end
                  default: begin
                     present_in = hit_ff;
                  end
               endcase
            end
         end
         stcrt_pkg::ST_POLL_SCAN: begin
            // Each pass finds the smallest tracked channel above the last one.
            if (!scan_done) begin
               idx_in = idx_ff + CB'(1);
               if (valid_ff[scan_idx] && (!prev_valid_ff || (chan_rd_ff > prev_ff))
                   && (!best_ff || (chan_rd_ff < best_chan_ff))) begin
                  best_in      = 1'b1;
                  best_idx_in  = scan_idx;
                  best_chan_in = chan_rd_ff;
               end
            end
         end
         stcrt_pkg::ST_POLL_AGE: begin
            age_in = {time_ff[TB-1], time_ff} - {act_rd_ff[TB-1], act_rd_ff};
         end
         stcrt_pkg::ST_POLL_CHECK: begin
            if (!stale || slot_free) begin
               prev_in       = best_chan_ff;
               prev_valid_in = 1'b1;
               best_in       = 1'b0;
               idx_in        = '0;
               if (stale) begin
                  act_we                = 1'b1;
                  count_in              = count_ff + stcrt_pkg::COUNT_BITS'(1);
                  emit                  = 1'b1;
                  emit_data.kind        = stcrt_pkg::KIND_REEMIT;
                  emit_data.out_channel = best_chan_ff;
                  emit_data.out_time_ns = time_ff;
                  emit_data.out_value   = stcrt_pkg::WORD_BITS'(val_rd_ff);
               end
            end
         end
         stcrt_pkg::ST_RESULT: begin
            if (slot_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               unique case (cmd_ff) inside
                  stcrt_pkg::CMD_WRITE: begin
                     emit_data.kind        = stcrt_pkg::KIND_FORWARD;
                     emit_data.out_channel = chan_ff;
                     emit_data.out_time_ns = time_ff;
                     emit_data.out_value   = stcrt_pkg::WORD_BITS'(value_ff);
                     emit_data.table_full  = full_ff;
                  end
                  stcrt_pkg::CMD_POLL: begin
                     emit_data.kind         = stcrt_pkg::KIND_DONE;
                     emit_data.reemit_count = count_ff;
                  end
                  default: begin
                     emit_data.kind       = stcrt_pkg::KIND_STATUS;
                     emit_data.is_present = present_ff;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stcrt_pkg::ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         interval_ff  <= stcrt_pkg::INTERVAL_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff  <= interval_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      chan_ff       <= chan_in;
      time_ff       <= time_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_chan_ff  <= best_chan_in;
      prev_valid_ff <= prev_valid_in;
      prev_ff       <= prev_in;
      count_ff      <= count_in;
      full_ff       <= full_in;
      present_ff    <= present_in;
      age_ff        <= age_in;
      rsp_ff        <= rsp_in;
   end

   // Table entries. Reads use the next scan index and the next best slot, so
   // the registered data lines up with the cycle that uses it.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         chan_mem[tbl_waddr] <= chan_ff;
         act_mem[tbl_waddr]  <= time_ff;
         val_mem[tbl_waddr]  <= value_ff;
      end
      if (act_we) begin
         act_mem[best_idx_ff] <= time_ff;
      end
      chan_rd_ff <= chan_mem[idx_in[IB-1:0]];
      act_rd_ff  <= act_mem[best_idx_in];
      val_rd_ff  <= val_mem[best_idx_in];
   end

endmodule

`default_nettype wire
